@@ rtl/core/ppr_pkg.sv @@
// ppr_pkg: shared constants, codes and pixel helper functions for the
// packed pixel to rgb565 converter
// depends on nothing; imported by the converter top level
package ppr_pkg;

	// palette storage
	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_W           = 24;

	// counter widths, fixed by the register widths
	localparam int COL_W = 11;
	localparam int ROW_W = 12;

	// configuration register indexes
	localparam logic [2:0] REG_DEPTH_MODE  = 3'd0;
	localparam logic [2:0] REG_IMAGE_WIDTH = 3'd1;
	localparam logic [2:0] REG_ROW_BYTES   = 3'd2;
	localparam logic [2:0] REG_TRANS_EN    = 3'd3;
	localparam logic [2:0] REG_TRANS_VALUE = 3'd4;

	// depth mode codes
	localparam logic [2:0] MODE_1BIT  = 3'd0;
	localparam logic [2:0] MODE_2BIT  = 3'd1;
	localparam logic [2:0] MODE_4BIT  = 3'd2;
	localparam logic [2:0] MODE_8BIT  = 3'd3;
	localparam logic [2:0] MODE_16BIT = 3'd4;

	// input item kinds
	localparam logic FUNC_DATA    = 1'b0;
	localparam logic FUNC_PAL_WR  = 1'b1;

	localparam logic [15:0] PIXEL_WHITE = 16'hFFFF;
	localparam logic [15:0] PIXEL_BLACK = 16'h0000;

	typedef logic [15:0] pixel_t;
	typedef logic [7:0]  slot_mask_t;

	// gray ramps, index 0 white, highest index black
	localparam logic [7:0] GRAY2_RAMP [4] = '{8'hff, 8'haa, 8'h55, 8'h00};
	localparam logic [7:0] GRAY4_RAMP [16] = '{
		8'hff, 8'hee, 8'hdd, 8'hcc, 8'hbb, 8'haa, 8'h99, 8'h88,
		8'h77, 8'h66, 8'h55, 8'h44, 8'h33, 8'h22, 8'h11, 8'h00
	};

	// pack 8-bit components into rgb565
	function automatic pixel_t rgb_to565(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	// pixels held in one stored byte; zero for 16-bit and undefined modes
	function automatic logic [3:0] pix_per_byte(input logic [2:0] mode);
		logic [3:0] n;
		case (mode)
			MODE_1BIT: n = 4'd8;
			MODE_2BIT: n = 4'd4;
			MODE_4BIT: n = 4'd2;
			MODE_8BIT: n = 4'd1;
			default:   n = 4'd0;
		endcase
		return n;
	endfunction

	// raw pixel code of one slot, msb-first inside the byte
	function automatic logic [15:0] slot_raw(input logic [2:0] mode, input logic [7:0] hi,
			input logic [7:0] byte_in, input logic [2:0] slot);
		logic [7:0]  sh2;
		logic [7:0]  sh4;
		logic [15:0] raw;
		sh2 = byte_in >> (3'd6 - {slot[1:0], 1'b0});
		sh4 = slot[0] ? byte_in : (byte_in >> 4);
		case (mode)
			MODE_1BIT:  raw = {15'd0, byte_in[3'd7 - slot]};
			MODE_2BIT:  raw = {14'd0, sh2[1:0]};
			MODE_4BIT:  raw = {12'd0, sh4[3:0]};
			MODE_8BIT:  raw = {8'd0, byte_in};
			MODE_16BIT: raw = {hi, byte_in};
			default:    raw = 16'd0;
		endcase
		return raw;
	endfunction

endpackage

@@ rtl/core/ppr_ram.sv @@
// ppr_ram: generic single write port, single read port ram with
// registered read data
// depends on nothing
module ppr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/packed_pixel_to_rgb565.sv @@
// packed_pixel_to_rgb565: bitmap byte stream to rgb565 pixel stream
// depends on ppr_pkg and ppr_ram (palette storage)
//
// the first pixel of a byte passes the slot stage and then the output register
// throughput: one pixel per cycle while the output is not stalled; a byte holds its slot stage
// until all its pixels are loaded (up to eight at 1 bit, one at 8 bits, one per byte pair at 16 bits),
// and the next byte is taken as its last pixel loads; palette writes and empty bytes do not hold it
// reset: config returns to defaults and row counters clear; palette is kept
module packed_pixel_to_rgb565
	import ppr_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,

	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,

	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: data_byte[7:0], palette_index[15:8], red[23:16], green[31:24], blue[39:32]
	input  logic [39:0] s_axis_tdata,
	input  logic        s_axis_tlast,  // end_of_image
	input  logic        s_axis_tuser,  // func

	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // pixel[15:0]
	output logic        m_axis_tlast   // last
);

	localparam logic [12:0] MAX_W = 13'(MAX_WIDTH);

	// configuration registers
	logic [2:0]       depth_mode_q;
	logic [COL_W-1:0] image_width_q;
	logic [ROW_W-1:0] row_bytes_q;
	logic             trans_en_q;
	logic [15:0]      trans_value_q;

	// row state
	logic [COL_W-1:0] column_q;
	logic [ROW_W-1:0] byte_count_q;
	logic [7:0]       held_high_q;

	// slot stage
	slot_mask_t       mask_s1;
	logic [7:0]       byte_s1;
	logic [7:0]       high_s1;

	// output register
	logic             out_valid_q;
	pixel_t           pixel_q;
	logic             last_q;

	logic [PAL_W-1:0] pal_rd_data;

	logic             in_xfer;
	logic             data_xfer;
	logic             pal_xfer;
	logic [7:0]       in_byte;
	logic [COL_W-1:0] width_eff;
	logic             col_open;
	logic [COL_W-1:0] col_rem;
	logic [3:0]       ppb;
	logic [3:0]       n_pix;
	logic             row_end;
	logic [ROW_W:0]   byte_count_inc;
	slot_mask_t       new_mask;

	slot_mask_t       sel_onehot;
	logic [2:0]       sel_slot;
	logic             out_load;
	logic             s1_done;
	logic [15:0]      emit_raw;
	pixel_t           emit_pixel;

	assign cfg_ready = 1'b1;

	assign in_xfer   = s_axis_tvalid && s_axis_tready;
	assign data_xfer = in_xfer && (s_axis_tuser == FUNC_DATA);
	assign pal_xfer  = in_xfer && (s_axis_tuser == FUNC_PAL_WR);
	assign in_byte   = s_axis_tdata[7:0];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_mode_q  <= MODE_8BIT;
			image_width_q <= COL_W'(320);
			row_bytes_q   <= ROW_W'(320);
			trans_en_q    <= 1'b0;
			trans_value_q <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEPTH_MODE:  depth_mode_q  <= cfg_data[2:0];
				REG_IMAGE_WIDTH: image_width_q <= cfg_data[COL_W-1:0];
				REG_ROW_BYTES:   row_bytes_q   <= cfg_data[ROW_W-1:0];
				REG_TRANS_EN:    trans_en_q    <= cfg_data[0];
				REG_TRANS_VALUE: trans_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// palette storage, read addressed by the incoming byte
	ppr_ram #(
		.WIDTH(PAL_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk    (clk),
		.wr_en  (pal_xfer),
		.wr_addr(s_axis_tdata[15:8]),
		.wr_data({s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]}),
		.rd_en  (data_xfer),
		.rd_addr(in_byte),
		.rd_data(pal_rd_data)
	);

	// pixels this byte yields in the current row
	always_comb begin
		width_eff = ({2'b00, image_width_q} > MAX_W) ? MAX_W[COL_W-1:0] : image_width_q;
		col_open  = column_q < width_eff;
		col_rem   = width_eff - column_q;
		ppb       = pix_per_byte(depth_mode_q);
		if (!col_open) begin
			n_pix = 4'd0;
		end else if (depth_mode_q == MODE_16BIT) begin
			n_pix = {3'd0, byte_count_q[0]};
		end else if (col_rem < {7'd0, ppb}) begin
			n_pix = col_rem[3:0];
		end else begin
			n_pix = ppb;
		end
	end

	// emit mask: slot in range and not transparent
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			new_mask[k] = (4'(k) < n_pix) &&
				!(trans_en_q && (slot_raw(depth_mode_q, held_high_q, in_byte, 3'(k))
					== trans_value_q));
		end
	end

	assign byte_count_inc = {1'b0, byte_count_q} + (ROW_W + 1)'(1);
	assign row_end        = s_axis_tlast || (byte_count_inc >= {1'b0, row_bytes_q});

	// row counters, updated as each data byte is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			byte_count_q <= '0;
			held_high_q  <= '0;
		end else if (data_xfer) begin
			if (row_end) begin
				column_q     <= '0;
				byte_count_q <= '0;
				held_high_q  <= '0;
			end else begin
				column_q     <= column_q + COL_W'(n_pix);
				byte_count_q <= byte_count_inc[ROW_W-1:0];
				if (depth_mode_q == MODE_16BIT && !byte_count_q[0]) begin
					held_high_q <= in_byte;
				end
			end
		end
	end

	// pick the lowest pending slot
	assign sel_onehot = mask_s1 & (~mask_s1 + 8'd1);
	always_comb begin
		sel_slot = 3'd0;
		for (int k = 0; k < 8; k++) begin
			if (sel_onehot[k]) begin
				sel_slot = 3'(k);
			end
		end
	end

	assign out_load      = (mask_s1 != '0) && (!out_valid_q || m_axis_tready);
	assign s1_done       = (mask_s1 & ~sel_onehot) == '0;
	assign s_axis_tready = (mask_s1 == '0) || (out_load && s1_done);

	// slot stage: byte and pending slot mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s1 <= '0;
		end else if (data_xfer) begin
			mask_s1 <= new_mask;
		end else if (out_load) begin
			mask_s1 <= mask_s1 & ~sel_onehot;
		end
	end

	always_ff @(posedge clk) begin
		if (data_xfer) begin
			byte_s1 <= in_byte;
			high_s1 <= held_high_q;
		end
	end

	// pixel value of the selected slot
	always_comb begin
		emit_raw = slot_raw(depth_mode_q, high_s1, byte_s1, sel_slot);
		case (depth_mode_q)
			MODE_1BIT:  emit_pixel = emit_raw[0] ? PIXEL_BLACK : PIXEL_WHITE;
			MODE_2BIT:  emit_pixel = rgb_to565(GRAY2_RAMP[emit_raw[1:0]],
				GRAY2_RAMP[emit_raw[1:0]], GRAY2_RAMP[emit_raw[1:0]]);
			MODE_4BIT:  emit_pixel = rgb_to565(GRAY4_RAMP[emit_raw[3:0]],
				GRAY4_RAMP[emit_raw[3:0]], GRAY4_RAMP[emit_raw[3:0]]);
			MODE_8BIT:  emit_pixel = rgb_to565(pal_rd_data[23:16], pal_rd_data[15:8],
				pal_rd_data[7:0]);
			MODE_16BIT: emit_pixel = emit_raw;
			default:    emit_pixel = PIXEL_BLACK;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_q <= emit_pixel;
			last_q  <= s1_done;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = pixel_q;
	assign m_axis_tlast  = last_q;

endmodule
